/* hdl/ofe_pkg.sv */
// ofe_pkg: shared types and constants for the opacity fade envelope
// used by ofe_ctrl, ofe_dp and opacity_fade_envelope; no dependencies
`default_nettype none

package ofe_pkg;

  localparam int LEVEL_W = 17;
  localparam int REM_W   = 18;
  localparam int GAP_W   = 17;
  localparam int CFG_W   = 16;
  localparam int DT_W    = 10;
  localparam int QUO_W   = DT_W + 16;
  localparam int CNT_W   = 5;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'h10000;
  localparam logic [GAP_W-1:0]   GAP_MAX    = 17'h1FFFF;
  localparam logic signed [REM_W:0] REM_MAX = 19'sh0_FFFF + 19'sh1_0000;
  localparam logic signed [REM_W:0] REM_MIN = -19'sh2_0000;
  localparam logic [CNT_W-1:0]   DIV_LAST_CNT = CNT_W'(QUO_W - 1);

  localparam logic [CFG_W-1:0] FADE_TIME_RST = 16'd3000;
  localparam logic [CFG_W-1:0] PULSE_GAP_RST = 16'd10000;
  localparam logic [GAP_W-1:0] GAP_ACC_RST   = 17'd10000;

  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_FADE_IN  = 2'd1;
  localparam logic [1:0] MODE_FADE_OUT = 2'd2;
  localparam logic [1:0] MODE_SET      = 2'd3;

  localparam logic [2:0] REG_FADE_TIME = 3'd0;
  localparam logic [2:0] REG_PULSE_GAP = 3'd1;
  localparam logic [2:0] REG_FLUCT_EN  = 3'd2;
  localparam logic [2:0] REG_PULSE_EN  = 3'd3;
  localparam logic [2:0] REG_RUN_EN    = 3'd4;

  typedef struct packed {
    logic load;
    logic div_step;
    logic apply;
  } ofe_cmd_t;

  typedef struct packed {
    logic tick_in;
    logic div_last;
  } ofe_status_t;

endpackage

`default_nettype wire

/* hdl/ofe_ctrl.sv */
// ofe_ctrl: sequencing state machine for the opacity fade envelope
// depends on ofe_pkg; drives the datapath ofe_dp through ofe_cmd_t
`default_nettype none

module ofe_ctrl
  import ofe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire ofe_status_t status,
  output ofe_cmd_t         cmd
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_APPLY} state_t;

  state_t state;

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.load     = in_valid && (state == S_IDLE);
    cmd.div_step = (state == S_DIV);
    cmd.apply    = (state == S_APPLY) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result slot: set on update, cleared by a transfer
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= status.tick_in ? S_DIV : S_APPLY;
          end
        end
        S_DIV: begin
          if (status.div_last) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (cmd.apply) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/ofe_dp.sv */
// ofe_dp: datapath of the opacity fade envelope: config registers,
// serial step divider and envelope state update; depends on ofe_pkg
`default_nettype none

module ofe_dp
  import ofe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic [1:0]         mode,
  input  wire logic [DT_W-1:0]    dt,
  input  wire logic [LEVEL_W-1:0] level,
  input  wire ofe_cmd_t           cmd,
  output ofe_status_t             status,
  output logic [LEVEL_W-1:0]      opacity,
  output logic                    fading_in
);

  // configuration
  logic [CFG_W-1:0] fade_time;
  logic [CFG_W-1:0] pulse_gap;
  logic             fluctuate_enable;
  logic             pulse_enable;
  logic             run_enable;

  // envelope state
  logic [LEVEL_W-1:0]      level_acc;
  logic signed [REM_W-1:0] remaining_time;
  logic [GAP_W-1:0]        gap_acc;
  logic                    rising;

  // latched item
  logic [1:0]         item_mode;
  logic [DT_W-1:0]    item_dt;
  logic [LEVEL_W-1:0] item_level;

  // divider
  logic [QUO_W-1:0] div_q;
  logic [15:0]      div_rem;
  logic [CNT_W-1:0] div_count;
  logic [15:0]      divisor;
  logic [16:0]      rem_shift;
  logic             take;

  logic [LEVEL_W-1:0]      step;
  logic [LEVEL_W:0]        lvl_sum;
  logic [LEVEL_W-1:0]      lvl_up;
  logic [LEVEL_W-1:0]      lvl_dn;
  logic signed [REM_W:0]   rem_up_w;
  logic signed [REM_W:0]   rem_dn_w;
  logic signed [REM_W-1:0] rem_up;
  logic signed [REM_W-1:0] rem_dn;
  logic signed [REM_W-1:0] fade_s;
  logic [GAP_W:0]          gap_sum;
  logic [GAP_W-1:0]        gap_sat;

  logic [LEVEL_W-1:0]      level_acc_next;
  logic signed [REM_W-1:0] remaining_time_next;
  logic [GAP_W-1:0]        gap_acc_next;
  logic                    rising_next;
  logic                    tri_run;

  assign status.tick_in  = (mode == MODE_TICK);
  assign status.div_last = (div_count == '0);
  assign opacity         = level_acc;
  assign fading_in       = rising;

  assign divisor   = (fade_time == '0) ? 16'd1 : fade_time;
  assign rem_shift = {div_rem, div_q[QUO_W-1]};
  assign take      = (rem_shift >= {1'b0, divisor});

  always_comb begin
    step   = (div_q > QUO_W'(FULL_LEVEL)) ? FULL_LEVEL : div_q[LEVEL_W-1:0];
    fade_s = $signed({2'b00, fade_time});

    lvl_sum = {1'b0, level_acc} + {1'b0, step};
    lvl_up  = (lvl_sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : lvl_sum[LEVEL_W-1:0];
    lvl_dn  = (level_acc > step) ? (level_acc - step) : '0;

    rem_up_w = {remaining_time[REM_W-1], remaining_time} + $signed({9'b0, item_dt});
    rem_dn_w = {remaining_time[REM_W-1], remaining_time} - $signed({9'b0, item_dt});
    rem_up   = (rem_up_w > REM_MAX) ? REM_MAX[REM_W-1:0] : rem_up_w[REM_W-1:0];
    rem_dn   = (rem_dn_w < REM_MIN) ? REM_MIN[REM_W-1:0] : rem_dn_w[REM_W-1:0];

    gap_sum = {1'b0, gap_acc} + {8'b0, item_dt};
    gap_sat = (gap_sum > {1'b0, GAP_MAX}) ? GAP_MAX : gap_sum[GAP_W-1:0];

    level_acc_next      = level_acc;
    remaining_time_next = remaining_time;
    gap_acc_next        = gap_acc;
    rising_next         = rising;
    tri_run             = 1'b0;

    case (item_mode)
      MODE_TICK: begin
        if (run_enable) begin
          if (pulse_enable) begin
            gap_acc_next = gap_sat;
            tri_run      = (gap_sat > {1'b0, pulse_gap});
          end else if (fluctuate_enable) begin
            tri_run = 1'b1;
          end else if (rising) begin
            if (remaining_time < fade_s) begin
              remaining_time_next = rem_up;
              level_acc_next      = lvl_up;
            end
          end else begin
            if (remaining_time > 0) begin
              remaining_time_next = rem_dn;
              level_acc_next      = lvl_dn;
            end
          end
          if (tri_run) begin
            if (!rising) begin
              remaining_time_next = rem_dn;
              level_acc_next      = lvl_dn;
              // falling ramp ended: turn round, pulse restarts its gap
              if (rem_dn[REM_W-1]) begin
                rising_next = 1'b1;
                if (pulse_enable) begin
                  gap_acc_next = '0;
                end
              end
            end else begin
              remaining_time_next = rem_up;
              level_acc_next      = lvl_up;
              if (rem_up > fade_s) begin
                rising_next = 1'b0;
              end
            end
          end
        end
      end
      MODE_FADE_IN: begin
        rising_next    = 1'b1;
        level_acc_next = '0;
      end
      MODE_FADE_OUT: begin
        rising_next    = 1'b0;
        level_acc_next = FULL_LEVEL;
      end
      MODE_SET: begin
        level_acc_next      = (item_level > FULL_LEVEL) ? FULL_LEVEL : item_level;
        remaining_time_next = fade_s;
      end
      default: begin
        level_acc_next = level_acc;
      end
    endcase
  end

  // item latch and restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode  <= mode;
      item_dt    <= dt;
      item_level <= level;
      div_q      <= {dt, 16'b0};
      div_rem    <= '0;
      div_count  <= DIV_LAST_CNT;
    end else if (cmd.div_step) begin
      div_q     <= {div_q[QUO_W-2:0], take};
      div_rem   <= take ? 16'(rem_shift - {1'b0, divisor}) : rem_shift[15:0];
      div_count <= div_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_time        <= FADE_TIME_RST;
      pulse_gap        <= PULSE_GAP_RST;
      fluctuate_enable <= 1'b0;
      pulse_enable     <= 1'b0;
      run_enable       <= 1'b1;
      level_acc        <= FULL_LEVEL;
      remaining_time   <= $signed({2'b00, FADE_TIME_RST});
      gap_acc          <= GAP_ACC_RST;
      rising           <= 1'b0;
    end else if (cmd.apply) begin
      level_acc      <= level_acc_next;
      remaining_time <= remaining_time_next;
      gap_acc        <= gap_acc_next;
      rising         <= rising_next;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FADE_TIME: begin
          fade_time      <= cfg_data;
          remaining_time <= $signed({2'b00, cfg_data});
        end
        REG_PULSE_GAP: pulse_gap        <= cfg_data;
        REG_FLUCT_EN:  fluctuate_enable <= cfg_data[0];
        REG_PULSE_EN:  pulse_enable     <= cfg_data[0];
        REG_RUN_EN:    run_enable       <= cfg_data[0];
        default: begin
          pulse_gap <= pulse_gap;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/opacity_fade_envelope.sv */
// opacity_fade_envelope: a tick item goes through the serial step divider, one
// quotient bit a cycle, and then the update; command items go straight to the
// update. one item in flight at a time, the next is taken while the result
// still waits in the output slot.
// rst is synchronous, active high: config and envelope state go to defaults
// depends on ofe_pkg, ofe_ctrl, ofe_dp
`default_nettype none

module opacity_fade_envelope
  import ofe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [DT_W-1:0]    dt,
  input  wire logic [LEVEL_W-1:0] level,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [LEVEL_W-1:0]      opacity,
  output logic                    fading_in
);

  // commands from the sequencer, status back from the datapath
  ofe_cmd_t    cmd;
  ofe_status_t status;

  // the result fields are the envelope state itself: it only changes on an
  // update, which waits until the previous result has had its transfer
  ofe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // config registers, step divider and level/time/gap update
  ofe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .dt        (dt),
    .level     (level),
    .cmd       (cmd),
    .status    (status),
    .opacity   (opacity),
    .fading_in (fading_in)
  );

endmodule

`default_nettype wire

/* sim/tb_opacity_fade_envelope.sv */
`timescale 1ns / 1ps
// tb_opacity_fade_envelope: self-checking bench for the opacity fade envelope,
// random ticks and fade commands over valid/ready, results checked in order
// depends on ofe_pkg and opacity_fade_envelope

module tb_opacity_fade_envelope;
  import ofe_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DT_MAX        = 1000;
  localparam int LONG_HOLD     = 300;
  // margin after the queues drain, longer than a tick's pass through the divider and update
  localparam int SETTLE_CYCLES = 32;
  localparam int LEVEL_TOP     = (1 << LEVEL_W) - 1;
  localparam int FULL_INT      = int'(FULL_LEVEL);
  localparam int GAP_TOP       = int'(GAP_MAX);

  // how a stretch of random items is shaped
  typedef enum int {PAT_MIXED, PAT_CLIMB, PAT_SINK} pattern_t;

  // one input item, plus the idle cycles the sender leaves after its transfer
  typedef struct packed {
    logic [1:0]         mode;
    logic [DT_W-1:0]    dt;
    logic [LEVEL_W-1:0] level;
    logic [2:0]         gap;
  } fade_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] opacity;
    logic               fading_in;
  } fade_result_t;

  // block ports, all inputs known from time zero
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = REG_FADE_TIME;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         mode      = MODE_TICK;
  logic [DT_W-1:0]    dt        = '0;
  logic [LEVEL_W-1:0] level     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LEVEL_W-1:0] opacity;
  logic               fading_in;

  opacity_fade_envelope uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .dt        (dt),
    .level     (level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .opacity   (opacity),
    .fading_in (fading_in)
  );

  // mirrored register file, starting from the reset defaults
  int fade_len = FADE_TIME_RST;
  int gap_len  = PULSE_GAP_RST;
  bit fluct_on = 1'b0;
  bit pulse_on = 1'b0;
  bit run_on   = 1'b1;

  // mirrored envelope state
  int env_level     = FULL_INT;
  int env_remaining = FADE_TIME_RST;
  int env_gap       = GAP_ACC_RST;
  bit env_rising    = 1'b0;

  // reach of the counters, for the closing summary
  int rem_peak  = FADE_TIME_RST;
  int rem_floor = FADE_TIME_RST;
  int gap_peak  = GAP_ACC_RST;

  fade_item_t   pending_items[$];
  fade_result_t expected_envelope[$];

  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   hold_left = 0;
  int   hold_requests = 0;
  int   holds_served  = 0;
  int   cycle_count = 0;
  int   failures = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   setups = 0;

  fade_item_t   taken;
  fade_item_t   next_item;
  fade_result_t want;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // envelope predictor
  // ---------------------------------------------------------------------------

  function automatic int clamp_remaining(int v);
    if (v > int'(REM_MAX)) return int'(REM_MAX);
    if (v < int'(REM_MIN)) return int'(REM_MIN);
    return v;
  endfunction

  // level change per tick: dt scaled to Q1.16 over the fade time, floored,
  // a zero fade time counts as one ms and the step never exceeds full scale
  function automatic int ramp_step(int d);
    longint quotient;
    quotient = (longint'(d) << 16) / longint'(fade_len == 0 ? 1 : fade_len);
    return quotient > longint'(FULL_INT) ? FULL_INT : int'(quotient);
  endfunction

  function automatic void ramp_down(int d, int s);
    env_remaining = clamp_remaining(env_remaining - d);
    env_level = env_level > s ? env_level - s : 0;
  endfunction

  function automatic void ramp_up(int d, int s);
    env_remaining = clamp_remaining(env_remaining + d);
    env_level = env_level + s > FULL_INT ? FULL_INT : env_level + s;
  endfunction

  // one leg of the triangle; high when a falling leg has just run out
  function automatic bit triangle_step(int d, int s);
    if (!env_rising) begin
      ramp_down(d, s);
      if (env_remaining < 0) begin
        env_rising = 1'b1;
        return 1'b1;
      end
    end else begin
      ramp_up(d, s);
      if (env_remaining > fade_len) env_rising = 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic fade_result_t predict_envelope(fade_item_t it);
    fade_result_t r;
    int d;
    int s;
    bit flipped;
    d = it.dt;
    s = ramp_step(d);
    case (it.mode)
      MODE_TICK: begin
        if (run_on) begin
          if (pulse_on) begin
            // gap builds up first; the triangle runs only once it passes the limit
            env_gap = env_gap + d > GAP_TOP ? GAP_TOP : env_gap + d;
            if (env_gap > gap_len) begin
              flipped = triangle_step(d, s);
              if (flipped) env_gap = 0;
            end
          end else if (fluct_on) begin
            flipped = triangle_step(d, s);
          end else if (env_rising) begin
            if (env_remaining < fade_len) ramp_up(d, s);
          end else if (env_remaining > 0) begin
            ramp_down(d, s);
          end
        end
      end
      MODE_FADE_IN: begin
        env_rising = 1'b1;
        env_level  = 0;
      end
      MODE_FADE_OUT: begin
        env_rising = 1'b0;
        env_level  = FULL_INT;
      end
      default: begin
        env_level     = it.level > FULL_LEVEL ? FULL_INT : int'(it.level);
        env_remaining = fade_len;
      end
    endcase
    if (env_remaining > rem_peak) rem_peak = env_remaining;
    if (env_remaining < rem_floor) rem_floor = env_remaining;
    if (env_gap > gap_peak) gap_peak = env_gap;
    r.opacity   = LEVEL_W'(env_level);
    r.fading_in = env_rising;
    return r;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_FADE_TIME: begin
        fade_len      = value;
        env_remaining = value;
      end
      REG_PULSE_GAP: gap_len  = value;
      REG_FLUCT_EN:  fluct_on = value[0];
      REG_PULSE_EN:  pulse_on = value[0];
      REG_RUN_EN:    run_on   = value[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int pause_len(bit quiet);
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  // single-bit registers get noise in the unused upper data bits
  function automatic logic [CFG_W-1:0] flag_word(bit b);
    return {15'($urandom), b};
  endfunction

  function automatic int random_dt();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? DT_MAX : 0;
    return $urandom_range(0, DT_MAX);
  endfunction

  task automatic push_item(logic [1:0] m, int d, int l, bit quiet);
    fade_item_t it;
    it.mode  = m;
    it.dt    = DT_W'(d);
    it.level = LEVEL_W'(l);
    it.gap   = 3'(pause_len(quiet));
    pending_items.push_back(it);
  endtask

  // wait until every item has gone through and the block has gone quiet
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_envelope.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    apply_register(idx, value);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(int ft, int pg, bit fl, bit pu, bit run, pattern_t pat,
                           int count, bit quiet, bit squeeze);
    int n;
    int pick;
    int lvl;
    settle();
    write_register(REG_FADE_TIME, CFG_W'(ft));
    write_register(REG_PULSE_GAP, CFG_W'(pg));
    write_register(REG_FLUCT_EN, flag_word(fl));
    write_register(REG_PULSE_EN, flag_word(pu));
    write_register(REG_RUN_EN, flag_word(run));
    setups++;
    // receiver sits on its ready while the sender keeps offering
    if (squeeze) hold_requests++;
    n = 0;
    while (n < count) begin
      if (pat != PAT_MIXED) begin
        // fade command then a long tick, over and over, drives the
        // remaining-time and gap counters out to their saturation points
        if ($urandom_range(0, 99) < 8) begin
          push_item(MODE_TICK, random_dt(), $urandom_range(0, LEVEL_TOP), quiet);
          n++;
        end else begin
          push_item(pat == PAT_CLIMB ? MODE_FADE_IN : MODE_FADE_OUT, random_dt(),
                    $urandom_range(0, LEVEL_TOP), quiet);
          push_item(MODE_TICK, $urandom_range(960, DT_MAX),
                    $urandom_range(0, LEVEL_TOP), quiet);
          n += 2;
        end
      end else begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0:       lvl = $urandom_range(0, 1) ? FULL_INT : 0;
          1:       lvl = $urandom_range(FULL_INT + 1, LEVEL_TOP);
          default: lvl = $urandom_range(0, FULL_INT);
        endcase
        if (pick < 70)
          push_item(MODE_TICK, random_dt(), $urandom_range(0, LEVEL_TOP), quiet);
        else if (pick < 78)
          push_item(MODE_FADE_IN, random_dt(), lvl, quiet);
        else if (pick < 86)
          push_item(MODE_FADE_OUT, random_dt(), lvl, quiet);
        else
          push_item(MODE_SET, random_dt(), lvl, quiet);
        n++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: one item per transfer, idle gap drawn per item
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      // free to move on: either nothing was offered or the last item went across
      if (send_wait > 0) begin
        in_valid  <= 1'b0;
        send_wait = send_wait - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        mode      <= next_item.mode;
        dt        <= next_item.dt;
        level     <= next_item.level;
        in_valid  <= 1'b1;
        send_wait = next_item.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall drawn after each transfer, plus the occasional long hold
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      // in every fourth window of the cycle counter the receiver draws no stall after a transfer
      if (out_fire) recv_wait = pause_len((cycle_count / 1024) % 4 == 3);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served = holds_served + 1;
        hold_left    = LONG_HOLD - 1;
        out_ready    <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait = recv_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on input transfer, compare on output transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        taken.mode  = mode;
        taken.dt    = dt;
        taken.level = level;
        taken.gap   = '0;
        expected_envelope.push_back(predict_envelope(taken));
        items_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_envelope.size() == 0) begin
          $error("opacity: result with nothing pending, got %0d", opacity);
          failures++;
        end else begin
          want = expected_envelope.pop_front();
          results_checked++;
          if (opacity !== want.opacity) begin
            $error("opacity: expected %0d, got %0d", want.opacity, opacity);
            failures++;
          end
          if (fading_in !== want.fading_in) begin
            $error("fading_in: expected %0d, got %0d", want.fading_in, fading_in);
            failures++;
          end
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // reset defaults, one-shot: fall until remaining time runs out, then stop
    push_item(MODE_TICK, 0, 0, 0);
    push_item(MODE_TICK, DT_MAX, LEVEL_TOP, 0);
    push_item(MODE_TICK, DT_MAX, 0, 0);
    push_item(MODE_TICK, DT_MAX, 0, 0);
    push_item(MODE_TICK, DT_MAX, 0, 0);
    push_item(MODE_FADE_IN, DT_MAX, LEVEL_TOP, 0);
    push_item(MODE_TICK, DT_MAX, 0, 0);
    // set level above full scale is held at full
    push_item(MODE_SET, 0, LEVEL_TOP, 0);
    push_item(MODE_SET, DT_MAX, 0, 0);
    push_item(MODE_SET, 0, FULL_INT, 0);
    push_item(MODE_FADE_OUT, 0, 0, 0);
    push_item(MODE_TICK, 7, 0, 0);
    settle();

    // zero fade time: step treated as a one ms divide and clipped at full scale
    write_register(REG_FADE_TIME, '0);
    write_register(REG_FLUCT_EN, flag_word(1'b1));
    setups++;
    push_item(MODE_FADE_IN, 0, 0, 0);
    push_item(MODE_TICK, DT_MAX, 0, 0);
    push_item(MODE_TICK, 1, 0, 0);
    settle();

    // run disabled: ticks leave everything alone, commands still land
    write_register(REG_RUN_EN, flag_word(1'b0));
    setups++;
    push_item(MODE_TICK, 500, 0, 0);
    push_item(MODE_FADE_OUT, 0, 0, 0);
    push_item(MODE_SET, 0, 12345, 0);
    settle();

    // writes past the last register must not disturb anything
    write_register(REG_RUN_EN, flag_word(1'b1));
    for (int i = int'(REG_RUN_EN) + 1; i < 8; i++)
      write_register(3'(i), CFG_W'($urandom));
    setups++;
    push_item(MODE_TICK, 300, 0, 0);
    settle();

    // pulse with no gap at the longest fade time
    write_register(REG_FADE_TIME, '1);
    write_register(REG_PULSE_GAP, '0);
    write_register(REG_PULSE_EN, flag_word(1'b1));
    setups++;
    push_item(MODE_TICK, 0, 0, 0);
    push_item(MODE_TICK, DT_MAX, 0, 0);
    push_item(MODE_FADE_IN, 0, 0, 0);
    push_item(MODE_TICK, DT_MAX, 0, 0);

    // random stretches under a spread of register settings
    run_phase($urandom_range(200, 3000), $urandom_range(0, 3000), 1'b0, 1'b0, 1'b1,
              PAT_MIXED, 60, 1'b0, 1'b0);
    run_phase(1, $urandom_range(0, 65535), 1'b1, 1'b0, 1'b1,
              PAT_MIXED, 50, 1'b1, 1'b0);
    run_phase($urandom_range(500, 2000), $urandom_range(0, 3000), 1'b0, 1'b1, 1'b1,
              PAT_MIXED, 60, 1'b0, 1'b1);
    // pulse with zero gap and 1 ms fades: remaining time and gap climb to the top
    run_phase(1, 0, 1'b0, 1'b1, 1'b1, PAT_CLIMB, 300, 1'b0, 1'b0);
    // fluctuate with repeated fade-outs: remaining time sinks to the bottom
    run_phase(1, $urandom_range(0, 65535), 1'b1, 1'b0, 1'b1, PAT_SINK, 300, 1'b0, 1'b0);
    run_phase(65535, 65535, 1'b1, 1'b1, 1'b1, PAT_MIXED, 50, 1'b0, 1'b0);
    run_phase($urandom_range(1, 65535), $urandom_range(0, 65535), $urandom_range(0, 1),
              $urandom_range(0, 1), 1'b0, PAT_MIXED, 30, 1'b1, 1'b0);
    run_phase($urandom_range(1, 5000), $urandom_range(0, 20000), $urandom_range(0, 1),
              $urandom_range(0, 1), 1'b1, PAT_MIXED, 50, 1'b0, 1'b0);
    settle();

    $display("%0d items over %0d register setups, %0d results compared",
             items_sent, setups, results_checked);
    $display("remaining time spanned %0d..%0d ms, gap accumulator peaked at %0d",
             rem_floor, rem_peak, gap_peak);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
